[hdl/ufbs_pkg.sv]
// shared types and constants for the fractional baud divisor search
package ufbs_pkg;

	localparam int PCLK_W = 26;
	localparam int BAUD_W = 22;
	localparam int DL_W = 16;
	localparam int FV_W = 4;
	localparam int DIV_W = 32;
	localparam int CNT_W = 6;
	localparam int MVP_W = 30;
	localparam int RDEN_W = 24;

	localparam logic [PCLK_W-1:0] PCLK_RESET = 26'd48000000;
	localparam logic [FV_W-1:0] MV_FIRST = 4'd1;
	localparam logic [FV_W-1:0] MV_LAST = 4'd15;
	localparam logic [FV_W-1:0] DAV_LAST = 4'd14;
	localparam logic [CNT_W-1:0] DIV_STEPS = 6'd32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_BWAIT,
		ST_PREP,
		ST_QSTART,
		ST_QWAIT,
		ST_RDEN,
		ST_RSTART,
		ST_RWAIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_BASE,
		OP_Q,
		OP_RATE
	} div_op_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		div_op_t op;
		logic    base_take;
		logic    prep;
		logic    q_take;
		logic    rden;
		logic    cmp;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic baud_zero;
		logic div_busy;
		logic div_done;
		logic rem_zero;
		logic last_pair;
		logic out_free;
	} sts_t;

endpackage

[hdl/ufbs_div.sv]
// radix-2 restoring unsigned divider, one quotient bit per cycle
module ufbs_div
	import ufbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DIV_W-1:0] remainder
);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0]   sh;
	logic             ge;

	assign sh = {rem_q, quo_q[DIV_W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_W'(sh - {1'b0, dvs_q}) : sh[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

[hdl/ufbs_dp.sv]
// datapath: operands, candidate arithmetic, best-pair tracking and result register
module ufbs_dp
	import ufbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic [PCLK_W-1:0] cfg_wdata,
	input  logic [BAUD_W-1:0] baud_rate,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [DL_W-1:0]   divisor_latch,
	output logic [FV_W-1:0]   div_add_val,
	output logic [FV_W-1:0]   mul_val
);

	logic [PCLK_W-1:0] pclk_q;
	logic [BAUD_W-1:0] baud_q;
	logic [FV_W-1:0]   mv_q;
	logic [FV_W-1:0]   dav_q;
	logic [DIV_W-1:0]  min_err_q;
	logic [DL_W-1:0]   dl_q;
	logic [FV_W-1:0]   bdav_q;
	logic [FV_W-1:0]   bmul_q;
	logic [MVP_W-1:0]  mvp_q;
	logic [DIV_W-1:0]  den_q;
	logic [DL_W-1:0]   dlv_q;
	logic [RDEN_W-1:0] rden_q;
	logic              out_valid_q;
	logic [DL_W-1:0]   out_dl_q;
	logic [FV_W-1:0]   out_dav_q;
	logic [FV_W-1:0]   out_mul_q;

	logic [DIV_W-1:0]  dvd;
	logic [DIV_W-1:0]  dvs;
	logic              div_busy;
	logic              div_done;
	logic [DIV_W-1:0]  quo;
	logic [DIV_W-1:0]  rem;
	logic [4:0]        sum;
	logic [DIV_W-1:0]  qt;
	logic [DL_W-1:0]   dlv;
	logic [DIV_W-1:0]  rt;
	logic [DIV_W-1:0]  rate;
	logic [DIV_W-1:0]  baud32;
	logic [DIV_W-1:0]  err;

	assign sum = {1'b0, dav_q} + {1'b0, mv_q};
	assign baud32 = DIV_W'(baud_q);

	always_comb begin
		case (cmd.op)
			OP_BASE: begin
				dvd = DIV_W'(pclk_q);
				dvs = DIV_W'({baud_q, 4'b0000});
			end
			OP_Q: begin
				dvd = {mvp_q, 2'b00};
				dvs = den_q;
			end
			OP_RATE: begin
				dvd = DIV_W'(mvp_q);
				dvs = DIV_W'(rden_q);
			end
			default: begin
				dvd = '0;
				dvs = '1;
			end
		endcase
	end

	ufbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_comb begin
		qt = {5'b0, quo[DIV_W-1:5]} + DIV_W'(1);
		dlv = qt[DL_W:1];
		if (dlv == '0) begin
			dlv = DL_W'(1);
		end
		if (dav_q != '0 && dlv < DL_W'(2)) begin
			dlv = DL_W'(2);
		end
		rt = quo + DIV_W'(1);
		rate = {1'b0, rt[DIV_W-1:1]};
		err = (rate >= baud32) ? rate - baud32 : baud32 - rate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pclk_q <= PCLK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pclk_q <= cfg_wdata;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			baud_q <= baud_rate;
			mv_q <= MV_FIRST;
			dav_q <= '0;
			min_err_q <= DIV_W'(baud_rate);
			dl_q <= '0;
			bdav_q <= '0;
			bmul_q <= MV_FIRST;
		end
		if (cmd.base_take) begin
			dl_q <= quo[DL_W-1:0];
		end
		if (cmd.prep) begin
			mvp_q <= MVP_W'(DIV_W'(pclk_q) * DIV_W'(mv_q));
			den_q <= DIV_W'(baud_q) * DIV_W'(sum);
		end
		if (cmd.q_take) begin
			dlv_q <= dlv;
		end
		if (cmd.rden) begin
			rden_q <= RDEN_W'({DIV_W'(dlv_q) * DIV_W'(sum), 3'b000});
		end
		if (cmd.cmp) begin
			if (err < min_err_q) begin
				min_err_q <= err;
				dl_q <= dlv_q;
				bdav_q <= dav_q;
				bmul_q <= mv_q;
			end
			if (dav_q + 1'b1 == mv_q) begin
				mv_q <= mv_q + 1'b1;
				dav_q <= '0;
			end else begin
				dav_q <= dav_q + 1'b1;
			end
		end
		if (cmd.out_load) begin
			out_dl_q <= dl_q;
			out_dav_q <= bdav_q;
			out_mul_q <= bmul_q;
		end
	end

	always_comb begin
		sts.baud_zero = baud_q == '0;
		sts.div_busy = div_busy;
		sts.div_done = div_done;
		sts.rem_zero = rem == '0;
		sts.last_pair = mv_q == MV_LAST && dav_q == DAV_LAST;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign divisor_latch = out_dl_q;
	assign div_add_val = out_dav_q;
	assign mul_val = out_mul_q;

endmodule

[hdl/ufbs_ctrl.sv]
// controller: sequences the base division and the candidate pair search
module ufbs_ctrl
	import ufbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.op = OP_BASE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.baud_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.op = OP_BASE;
					state_d = ST_BWAIT;
				end
			end
			ST_BWAIT: begin
				if (sts.div_done) begin
					cmd.base_take = 1'b1;
					state_d = sts.rem_zero ? ST_DONE : ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_QSTART;
			end
			ST_QSTART: begin
				cmd.div_start = 1'b1;
				cmd.op = OP_Q;
				state_d = ST_QWAIT;
			end
			ST_QWAIT: begin
				if (sts.div_done) begin
					cmd.q_take = 1'b1;
					state_d = ST_RDEN;
				end
			end
			ST_RDEN: begin
				cmd.rden = 1'b1;
				state_d = ST_RSTART;
			end
			ST_RSTART: begin
				cmd.div_start = 1'b1;
				cmd.op = OP_RATE;
				state_d = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (sts.div_done) begin
					cmd.cmp = 1'b1;
					state_d = sts.last_pair ? ST_DONE : ST_PREP;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !sts.div_busy)
		else $error("divider done while busy");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");
`endif

endmodule

[hdl/uart_fractional_baud_search_top.sv]
// top level of the fractional uart baud divisor search
//
//  channel  signals                                  width
//  cfg      cfg_we, cfg_wdata                        26
//  in       in_valid, in_ready, baud_rate            22
//  out      out_valid, out_ready, divisor_latch,     16
//           div_add_val, mul_val                     4, 4
//
// one beat at a time: when the clock divides evenly the result needs only the base division
// (none for a zero rate), else the search also runs 120 candidate pairs, all on the shared
// serial divider (one base division, then two divisions per candidate pair)
// reset clears the state machine and result valid and sets pclk_q to 48 MHz
// a finished result waits in the output register while the next beat is taken
module uart_fractional_baud_search_top
	import ufbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PCLK_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BAUD_W-1:0] baud_rate,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DL_W-1:0]   divisor_latch,
	output logic [FV_W-1:0]   div_add_val,
	output logic [FV_W-1:0]   mul_val
);

	cmd_t cmd;
	sts_t sts;

	ufbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ufbs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.baud_rate     (baud_rate),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.divisor_latch (divisor_latch),
		.div_add_val   (div_add_val),
		.mul_val       (mul_val)
	);

endmodule

[dv/testbench.sv]
// testbench for the fractional uart baud divisor search: directed table, then random beats
module testbench
	import ufbs_pkg::*;
();

	localparam int CYCLE_LIMIT = 6000000;
	localparam int SETTLE = 40;

	typedef struct packed {
		logic [DL_W-1:0] dl;
		logic [FV_W-1:0] dav;
		logic [FV_W-1:0] mv;
	} baud_setting_t;

	typedef struct {
		logic [PCLK_W-1:0] pclk;
		logic [BAUD_W-1:0] baud;
		bit                known;
		baud_setting_t     want;
	} table_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [PCLK_W-1:0] cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BAUD_W-1:0] baud_rate = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DL_W-1:0]   divisor_latch;
	logic [FV_W-1:0]   div_add_val;
	logic [FV_W-1:0]   mul_val;

	baud_setting_t     pending_settings[$];
	logic [PCLK_W-1:0] pclk_shadow = PCLK_RESET;
	int                mismatches = 0;
	int                cycles = 0;
	int                stall_left = 0;
	bit                out_quiet = 1'b0;

	uart_fractional_baud_search_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .baud_rate(baud_rate),
		.out_valid(out_valid), .out_ready(out_ready), .divisor_latch(divisor_latch),
		.div_add_val(div_add_val), .mul_val(mul_val)
	);

	always #10 clk = ~clk;

	function automatic baud_setting_t best_divisor(bit [31:0] pclk, bit [31:0] baud);
		baud_setting_t r;
		bit [31:0] div16, min_err, den, q, dlv, rate, err, mv, dav;
		r.dl = '0;
		r.dav = '0;
		r.mv = 4'd1;
		if (baud != 0) begin
			div16 = 32'd16 * baud;
			r.dl = 16'(pclk / div16);
			if (pclk % div16 != 0) begin
				min_err = baud;
				for (mv = 1; mv < 16; mv++) begin
					for (dav = 0; dav < mv; dav++) begin
						den = baud * (dav + mv);
						if (((mv * pclk * 32'd2) & 32'h8000_0000) != 0)
							q = (((32'd2 * mv * pclk) / den) / 32'd16 + 32'd1) / 32'd2;
						else
							q = (((32'd4 * mv * pclk) / den) / 32'd32 + 32'd1) / 32'd2;
						dlv = q & 32'hFFFF;
						if (dlv == 0)
							dlv = 1;
						if (dav > 0 && dlv < 2)
							dlv = 2;
						rate = ((pclk * mv) / (dlv * (dav + mv) * 32'd8) + 32'd1) / 32'd2;
						err = (rate >= baud) ? rate - baud : baud - rate;
						if (err < min_err) begin
							min_err = err;
							r.dl = 16'(dlv);
							r.mv = 4'(mv);
							r.dav = 4'(dav);
						end
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: compare each beat, then pick the next ready value
	always @(posedge clk) begin
		baud_setting_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_settings.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result dl=%0d dav=%0d mv=%0d",
						divisor_latch, div_add_val, mul_val);
			end else begin
				want = pending_settings.pop_front();
				if (want.dl !== divisor_latch || want.dav !== div_add_val ||
				    want.mv !== mul_val) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: exp dl=%0d dav=%0d mv=%0d got dl=%0d dav=%0d mv=%0d",
							want.dl, want.dav, want.mv, divisor_latch, div_add_val,
							mul_val);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!out_quiet) begin
				if ($urandom_range(0, 49) == 0)
					stall_left <= $urandom_range(20, 300);
				else if ($urandom_range(0, 7) == 0)
					stall_left <= $urandom_range(1, 3);
			end
		end
	end

	task automatic send_baud(input logic [BAUD_W-1:0] b, input bit with_gaps);
		int gap;
		gap = 0;
		if (with_gaps)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		baud_rate <= b;
		do @(posedge clk); while (!in_ready);
		pending_settings.push_back(best_divisor(32'(pclk_shadow), 32'(b)));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_settings.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_pclk(input logic [PCLK_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pclk_shadow = v;
	endtask

	table_row_t directed[] = '{
		'{26'd48000000, 22'd0,       1'b1, '{16'd0,     4'd0, 4'd1}},
		'{26'd48000000, 22'd3000000, 1'b1, '{16'd1,     4'd0, 4'd1}},
		'{26'd48000000, 22'd1,       1'b1, '{16'd50880, 4'd0, 4'd1}},
		'{26'd48000000, 22'd250000,  1'b1, '{16'd12,    4'd0, 4'd1}},
		'{26'd48000000, 22'd115200,  1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'd48000000, 22'd9600,    1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'd48000000, 22'd4194303, 1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'd0,        22'd9600,    1'b1, '{16'd0,     4'd0, 4'd1}},
		'{26'd0,        22'd4194303, 1'b1, '{16'd0,     4'd0, 4'd1}},
		'{26'd1,        22'd1,       1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'd1,        22'd0,       1'b1, '{16'd0,     4'd0, 4'd1}},
		'{26'h3FFFFFF,  22'd1,       1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'h3FFFFFF,  22'd115200,  1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'h3FFFFFF,  22'd4194303, 1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'd50000000, 22'd3125,    1'b1, '{16'd1000,  4'd0, 4'd1}},
		'{26'd50000000, 22'd1000000, 1'b0, '{16'd0,     4'd0, 4'd0}},
		'{26'd50000000, 22'd3000000, 1'b0, '{16'd0,     4'd0, 4'd0}}
	};

	int even_k[] = '{1, 2, 3, 4, 5, 6, 8, 10, 12, 16, 20};

	initial begin
		logic [PCLK_W-1:0] phase_pclk;
		logic [BAUD_W-1:0] b;
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].pclk != pclk_shadow) begin
				drain();
				write_pclk(directed[i].pclk);
			end
			send_baud(directed[i].baud, 1'b0);
			if (directed[i].known)
				pending_settings[pending_settings.size()-1] = directed[i].want;
		end

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: phase_pclk = PCLK_W'($urandom_range(1, 50000000));
				1: phase_pclk = 26'd3072000;
				2: phase_pclk = PCLK_W'(32'h3FFFFFF - $urandom_range(0, 1000));
				default: phase_pclk = PCLK_W'($urandom_range(1000000, 50000000));
			endcase
			write_pclk(phase_pclk);
			out_quiet = (phase == 3);
			for (int n = 0; n < 23; n++) begin
				pick = $urandom_range(0, 9);
				if (phase == 1 && pick < 4)
					b = 22'(192000 / even_k[$urandom_range(0, 10)]);
				else if (pick == 4)
					b = BAUD_W'($urandom_range(1, 2000));
				else if (pick == 5)
					b = BAUD_W'($urandom_range(0, 32'h3FFFFF));
				else
					b = BAUD_W'($urandom_range(1, 3000000));
				if (n == 12)
					drain();
				send_baud(b, phase != 3 || n > 15);
			end
		end

		drain();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[files.f]
hdl/ufbs_pkg.sv
hdl/ufbs_div.sv
hdl/ufbs_dp.sv
hdl/ufbs_ctrl.sv
hdl/uart_fractional_baud_search_top.sv
dv/testbench.sv
